// ===== rtl/core/sal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sal_pkg
// Shared codes and control/status types for the shifting array list.
// ----------------------------------------------------------------------------
package sal_pkg;

    // function codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;
    localparam logic [1:0] ERR_EMPTY = 2'd3;

    // field widths of a word
    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int FIDX_W  = 4;
    localparam int CNT_O_W = 5;

    // controller -> datapath
    typedef struct packed {
        logic exec;   // input word accepted, run the operation
        logic step;   // one find compare this cycle
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_start;  // request word is a find on a non-empty list
        logic hit;         // current find compare matched
        logic last;        // current find compare is on the last entry
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/sal_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sal_ctrl
// Sequencer: handshakes, find scan sequencing, output valid.
// ----------------------------------------------------------------------------
module sal_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output sal_pkg::cmd_t      cmd,
    input  wire sal_pkg::sts_t sts
);
    import sal_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic accept;
    logic scan_done;

    assign s_axis_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign scan_done     = (state_reg == ST_SCAN) && (sts.hit || sts.last);
    assign m_axis_tvalid = m_valid_reg;

    assign cmd.exec = accept;
    assign cmd.step = (state_reg == ST_SCAN);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && sts.scan_start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.hit || sts.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if ((accept && !sts.scan_start) || scan_done)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sal_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sal_datapath
// Entry cells with shift paths, count, find compare, result register.
// ----------------------------------------------------------------------------
module sal_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [sal_pkg::FUNC_W-1:0]         func,
    input  wire logic signed [sal_pkg::VALUE_W-1:0] value,
    input  wire logic [sal_pkg::POS_W-1:0]          position,
    input  wire sal_pkg::cmd_t                      cmd,
    output sal_pkg::sts_t                           sts,
    output logic signed [sal_pkg::VALUE_W-1:0]      read_value,
    output logic                                    found,
    output logic [sal_pkg::FIDX_W-1:0]              found_index,
    output logic [sal_pkg::CNT_O_W-1:0]             entry_count,
    output logic                                    is_empty,
    output logic [1:0]                              error_code
);
    import sal_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic signed [DATA_WIDTH-1:0] entries_reg  [DEPTH];
    logic signed [DATA_WIDTH-1:0] entries_next [DEPTH];
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic signed [DATA_WIDTH-1:0] key_reg;
    logic [IDX_W-1:0]             idx_reg;

    logic signed [VALUE_W-1:0]    read_value_reg;
    logic                         found_reg;
    logic [FIDX_W-1:0]            found_index_reg;
    logic [CNT_O_W-1:0]           entry_count_reg;
    logic                         is_empty_reg;
    logic [1:0]                   error_code_reg;

    logic signed [DATA_WIDTH-1:0] val_w;
    logic [CMP_W-1:0]             pos_w;
    logic [CMP_W-1:0]             cnt_w;
    logic [IDX_W-1:0]             addr;
    logic [IDX_W-1:0]             rd_addr;
    logic signed [DATA_WIDTH-1:0] rd_entry;
    logic                         op_ok;
    logic [1:0]                   op_err;
    logic                         do_ins;
    logic                         do_del;
    logic                         do_wr;
    logic                         is_find;

    assign val_w = DATA_WIDTH'(value);
    assign pos_w = CMP_W'(position);
    assign cnt_w = CMP_W'(count_reg);
    assign addr  = pos_w[IDX_W-1:0];

    // single read port: find index while scanning, else the addressed position
    assign rd_addr  = cmd.step ? idx_reg : addr;
    assign rd_entry = entries_reg[rd_addr];

    assign is_find = (func == OP_FIND);

    always_comb
    begin
        op_ok  = 1'b0;
        op_err = ERR_OK;
        unique case (func) inside
            OP_INSERT:
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    op_err = ERR_FULL;
                end
                else if (pos_w > cnt_w)
                begin
                    op_err = ERR_RANGE;
                end
                else
                begin
                    op_ok = 1'b1;
                end
            end
            OP_DELETE, OP_READ, OP_WRITE:
            begin
                if (count_reg == '0)
                begin
                    op_err = ERR_EMPTY;
                end
                else if (pos_w >= cnt_w)
                begin
                    op_err = ERR_RANGE;
                end
                else
                begin
                    op_ok = 1'b1;
                end
            end
            OP_FIND:
            begin
                if (count_reg == '0)
                begin
                    op_err = ERR_EMPTY;
                end
                else
                begin
                    op_ok = 1'b1;
                end
            end
            default:
            begin
                op_ok  = 1'b0;
                op_err = ERR_OK;
            end
        endcase
    end

    assign do_ins = cmd.exec && op_ok && (func == OP_INSERT);
    assign do_del = cmd.exec && op_ok && (func == OP_DELETE);
    assign do_wr  = cmd.exec && op_ok && (func == OP_WRITE);

    assign sts.scan_start = op_ok && is_find;
    assign sts.hit        = (rd_entry == key_reg);
    assign sts.last       = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // each cell picks its neighbour below (insert) or above (delete), or the new value at the position (insert, write)
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            entries_next[i] = entries_reg[i];
            if (do_ins)
            begin
                if (IDX_W'(i) == addr)
                begin
                    entries_next[i] = val_w;
                end
                else if ((i > 0) && (IDX_W'(i) > addr))
                begin
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_del)
            begin
                if ((i < DEPTH - 1) && (IDX_W'(i) >= addr))
                begin
                    entries_next[i] = entries_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
            else if (do_wr && (IDX_W'(i) == addr))
            begin
                entries_next[i] = val_w;
            end
        end

        always_ff @(posedge clk)
        begin
            entries_reg[i] <= entries_next[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // find key, scan index and result word
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            key_reg <= val_w;
            idx_reg <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end

        if (cmd.exec && !(op_ok && is_find))
        begin
            read_value_reg  <= (op_ok && (func == OP_READ)) ? VALUE_W'(rd_entry) : '0;
            found_reg       <= 1'b0;
            found_index_reg <= '0;
            entry_count_reg <= CNT_O_W'(count_next);
            is_empty_reg    <= (count_next == '0);
            error_code_reg  <= op_err;
        end
        else if (cmd.step && (sts.hit || sts.last))
        begin
            read_value_reg  <= '0;
            found_reg       <= sts.hit;
            found_index_reg <= sts.hit ? FIDX_W'(idx_reg) : '0;
            entry_count_reg <= CNT_O_W'(count_reg);
            is_empty_reg    <= (count_reg == '0);
            error_code_reg  <= ERR_OK;
        end
    end

    assign read_value  = read_value_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign error_code  = error_code_reg;

endmodule
`default_nettype wire

// ===== rtl/core/shifting_array_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shifting_array_list
// Bounded ordered list of signed words: insert, delete, read, write, find.
// ----------------------------------------------------------------------------
// Usage:
//   One request word in on the s_axis channel, one result word out on the
//   m_axis channel for every request, in order.
//   Insert, delete, read and write run in the cycle the request is taken;
//   the result word is valid from the next cycle.
//   Find walks the entries from index 0 with a single comparator, one entry
//   per cycle, stopping at the first match or the last entry.
//   Refused requests (full, empty, out of range) and unknown codes also give
//   their result word from the next cycle and leave the list unchanged.
//   The result sits in an output register; a new request is taken while it
//   waits only if it is being read in the same cycle. A stalled receiver
//   holds the result and back-pressures the request side.
//   Reset empties the list (count zero). Entry contents are not cleared and
//   need no clearing pass: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module shifting_array_list #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request: [2:0] func, [34:3] value, [39:35] position
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    // result: [31:0] read_value, [32] found, [36:33] found_index,
    //         [41:37] entry_count, [42] is_empty, [44:43] error_code,
    //         [47:45] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata
);
    import sal_pkg::*;

    cmd_t                      cmd;
    sts_t                      sts;
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] read_value;
    logic                      found;
    logic [FIDX_W-1:0]         found_index;
    logic [CNT_O_W-1:0]        entry_count;
    logic                      is_empty;
    logic [1:0]                error_code;

    // unpack request word
    assign func     = s_axis_tdata[2:0];
    assign value    = s_axis_tdata[34:3];
    assign position = s_axis_tdata[39:35];

    sal_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    sal_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (func),
        .value       (value),
        .position    (position),
        .cmd         (cmd),
        .sts         (sts),
        .read_value  (read_value),
        .found       (found),
        .found_index (found_index),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .error_code  (error_code)
    );

    // pack result word, high field first in the concatenation
    assign m_axis_tdata = {3'b000, error_code, is_empty, entry_count,
                           found_index, found, read_value};

endmodule
`default_nettype wire
